@@ design/i2cbb_pkg.sv @@
// Shared types and constants for the I2C bit-bang master.
package i2cbb_pkg;

   localparam int DelayWidthDef = 16;
   localparam int CfgWidth      = 16;
   localparam logic [CfgWidth-1:0] DelayReset = 16'd50;
   localparam int ByteWidth     = 8;
   localparam int BitCntWidth   = 4;
   localparam logic [BitCntWidth-1:0] BitsPerByte = 4'd8;
   localparam int CsrAddrWidth  = 2;
   localparam int CsrDataWidth  = 32;
   localparam logic [CsrAddrWidth-1:0] CsrDelayAddr = '0;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_STOP  = 2'd1,
      CMD_WRITE = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   // one tick of bus result
   typedef struct packed {
      logic [ByteWidth-1:0] rd_data;
      logic                 done;
      logic                 busy;
      logic                 sda;
      logic                 scl;
   } result_type;

endpackage

@@ design/i2cbb_seq.sv @@
// Bus sequencer: state registers and per-tick next-state logic.
module i2cbb_seq #(
   parameter int DELAY_WIDTH = i2cbb_pkg::DelayWidthDef
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic                                cmd_valid,
   input  i2cbb_pkg::cmd_type                  mode,
   input  logic [i2cbb_pkg::ByteWidth-1:0]     wr_data,
   input  logic                                sda_in,
   input  logic [i2cbb_pkg::CfgWidth-1:0]      delay_ticks,
   output i2cbb_pkg::result_type               result
);
   import i2cbb_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_START_A  = 4'd1,
      PH_START_B  = 4'd2,
      PH_STOP_A   = 4'd3,
      PH_STOP_B   = 4'd4,
      PH_STOP_C   = 4'd5,
      PH_BIT_HIGH = 4'd6,
      PH_BIT_LOW  = 4'd7,
      PH_ACK_HIGH = 4'd8,
      PH_ACK_POLL = 4'd9,
      PH_ACK_LOW  = 4'd10
   } phase_type;

   phase_type              phase_ff, phase_in;
   cmd_type                cmd_ff, cmd_in;
   logic [BitCntWidth-1:0] bit_cnt_ff, bit_cnt_in, bit_cnt_inc;
   logic [ByteWidth-1:0]   shift_ff, shift_in;
   logic [ByteWidth-1:0]   rd_hold_ff, rd_hold_in;
   logic [DELAY_WIDTH-1:0] wait_ff, wait_in;
   logic                   scl_ff, scl_in;
   logic                   sda_ff, sda_in_drv;
   logic                   done;
   logic [DELAY_WIDTH-1:0] delay_mask;
   logic [DELAY_WIDTH-1:0] delay_load;
   logic                   delay_over;
   logic [DELAY_WIDTH-1:0] wait_dec;

   always_comb begin
      delay_mask = DELAY_WIDTH'(delay_ticks);
      delay_load = (delay_mask == '0) ? DELAY_WIDTH'(1) : delay_mask;
   end

   assign delay_over  = (wait_ff <= DELAY_WIDTH'(1));
   assign wait_dec    = delay_over ? wait_ff : wait_ff - DELAY_WIDTH'(1);
   assign bit_cnt_inc = bit_cnt_ff + BitCntWidth'(1);

   always_comb begin
      phase_in   = phase_ff;
      cmd_in     = cmd_ff;
      bit_cnt_in = bit_cnt_ff;
      shift_in   = shift_ff;
      rd_hold_in = rd_hold_ff;
      wait_in    = wait_dec;
      scl_in     = scl_ff;
      sda_in_drv = sda_ff;
      done       = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            wait_in = wait_ff;
            if (cmd_valid) begin
               cmd_in     = mode;
               bit_cnt_in = '0;
               wait_in    = delay_load;
               unique case (mode)
                  CMD_START: begin
                     scl_in = 1'b1; sda_in_drv = 1'b1; phase_in = PH_START_A;
                  end
                  CMD_STOP: begin
                     scl_in = 1'b0; sda_in_drv = 1'b0; phase_in = PH_STOP_A;
                  end
                  CMD_WRITE: begin
                     scl_in     = 1'b1;
                     sda_in_drv = wr_data[ByteWidth-1];
                     shift_in   = {wr_data[ByteWidth-2:0], 1'b0};
                     phase_in   = PH_BIT_HIGH;
                  end
                  default: begin
                     scl_in = 1'b1; sda_in_drv = 1'b1;
                     shift_in = '0; phase_in = PH_BIT_HIGH;
                  end
               endcase
            end
         end
         PH_START_A: if (delay_over) begin
            sda_in_drv = 1'b0; phase_in = PH_START_B; wait_in = delay_load;
         end
         PH_START_B: if (delay_over) begin
            scl_in = 1'b0; phase_in = PH_IDLE; done = 1'b1;
         end
         PH_STOP_A: if (delay_over) begin
            scl_in = 1'b1; phase_in = PH_STOP_B; wait_in = delay_load;
         end
         PH_STOP_B: if (delay_over) begin
            sda_in_drv = 1'b1; phase_in = PH_STOP_C; wait_in = delay_load;
         end
         PH_STOP_C: if (delay_over) begin
            phase_in = PH_IDLE; done = 1'b1;
         end
         PH_BIT_HIGH: if (delay_over) begin
            if (cmd_ff == CMD_READ) begin
               shift_in = {shift_ff[ByteWidth-2:0], sda_in};
            end
            scl_in = 1'b0; phase_in = PH_BIT_LOW; wait_in = delay_load;
         end
         PH_BIT_LOW: if (delay_over) begin
            bit_cnt_in = bit_cnt_inc;
            wait_in    = delay_load;
            if (bit_cnt_inc < BitsPerByte) begin
               if (cmd_ff == CMD_WRITE) begin
                  sda_in_drv = shift_ff[ByteWidth-1];
                  shift_in   = {shift_ff[ByteWidth-2:0], 1'b0};
               end
               scl_in = 1'b1; phase_in = PH_BIT_HIGH;
            end else begin
               scl_in = 1'b1; sda_in_drv = 1'b1; phase_in = PH_ACK_HIGH;
            end
         end
         PH_ACK_HIGH: if (delay_over) begin
            if (cmd_ff == CMD_READ) begin
               scl_in = 1'b0; rd_hold_in = shift_ff;
               phase_in = PH_IDLE; done = 1'b1;
            end else if (!sda_in) begin
               scl_in = 1'b0; phase_in = PH_ACK_LOW; wait_in = delay_load;
            end else begin
               phase_in = PH_ACK_POLL;
            end
         end
         PH_ACK_POLL: begin
            wait_in = wait_ff;
            if (!sda_in) begin
               scl_in = 1'b0; phase_in = PH_ACK_LOW; wait_in = delay_load;
            end
         end
         PH_ACK_LOW: if (delay_over) begin
            phase_in = PH_IDLE; done = 1'b1;
         end
         default: begin
            wait_in  = wait_ff;
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         cmd_ff     <= CMD_START;
         bit_cnt_ff <= '0;
         shift_ff   <= '0;
         rd_hold_ff <= '0;
         wait_ff    <= '0;
         scl_ff     <= 1'b1;
         sda_ff     <= 1'b1;
      end else if (step) begin
         phase_ff   <= phase_in;
         cmd_ff     <= cmd_in;
         bit_cnt_ff <= bit_cnt_in;
         shift_ff   <= shift_in;
         rd_hold_ff <= rd_hold_in;
         wait_ff    <= wait_in;
         scl_ff     <= scl_in;
         sda_ff     <= sda_in_drv;
      end
   end

   assign result.scl     = scl_in;
   assign result.sda     = sda_in_drv;
   assign result.busy    = (phase_in != PH_IDLE);
   assign result.done    = done;
   assign result.rd_data = rd_hold_in;

endmodule

@@ design/i2c_bitbang_master_unit.sv @@
// Top level of the I2C bit-bang master: stream ports, CSR and result register.
// Each input word is one bus tick and yields exactly one result word showing
// SCL/SDA drive, busy, done and the last read byte after that tick. One word
// is taken per clock; the result appears in the output register in the cycle after
// acceptance, and the input stays ready while that register is empty or
// being drained, so full rate is held as long as the result side keeps up.
// The single register delay_ticks (byte address 0, reset 50) sets the ticks
// per bus delay; zero acts as one. Write it only while no command is running.
module i2c_bitbang_master_unit #(
   parameter int DELAY_WIDTH = i2cbb_pkg::DelayWidthDef
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [15:0]                            req_tdata,  // wr_data[7:0], sda_in[8]
   input  logic [2:0]                             req_tuser,  // cmd_valid[0], mode[2:1]
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [15:0]                            rsp_tdata,
   // scl_out[0], sda_out[1], busy_res[2], done_res[3], rd_data[11:4]
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [i2cbb_pkg::CsrAddrWidth-1:0]     csr_paddr,
   input  logic [i2cbb_pkg::CsrDataWidth-1:0]     csr_pwdata,
   output logic [i2cbb_pkg::CsrDataWidth-1:0]     csr_prdata,
   output logic                                   csr_pready
);
   import i2cbb_pkg::*;

   logic [CfgWidth-1:0] delay_ff;
   logic                csr_wr;
   logic                accept;
   result_type          result;
   result_type          rsp_ff;
   logic                rsp_tvalid_ff, rsp_tvalid_in;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = CsrDataWidth'(delay_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DelayReset;
      end else if (csr_wr && csr_paddr == CsrDelayAddr) begin
         delay_ff <= csr_pwdata[CfgWidth-1:0];
      end
   end

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   i2cbb_seq #(
      .DELAY_WIDTH(DELAY_WIDTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .step       (accept),
      .cmd_valid  (req_tuser[0]),
      .mode       (cmd_type'(req_tuser[2:1])),
      .wr_data    (req_tdata[ByteWidth-1:0]),
      .sda_in     (req_tdata[ByteWidth]),
      .delay_ticks(delay_ff),
      .result     (result)
   );

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (accept) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'b0000, rsp_ff};

`ifndef SYNTHESIS
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[3] && rsp_tdata[2]))
      else $error("done and busy reported together");

   a_accept_gives_word: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted word produced no result");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |-> req_tready)
      else $error("input stalled while result drains");
`endif

endmodule

@@ tb/sv/i2c_tick_sb_pkg.sv @@
`timescale 1ns / 100ps
// Scoreboard class holding a tick-accurate predictor of the I2C bit-bang master.
package i2c_tick_sb_pkg;
   import i2cbb_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_START_A  = 4'd1,
      PH_START_B  = 4'd2,
      PH_STOP_A   = 4'd3,
      PH_STOP_B   = 4'd4,
      PH_STOP_C   = 4'd5,
      PH_BIT_HIGH = 4'd6,
      PH_BIT_LOW  = 4'd7,
      PH_ACK_HIGH = 4'd8,
      PH_ACK_POLL = 4'd9,
      PH_ACK_LOW  = 4'd10
   } seq_phase_e;

   class i2c_tick_scoreboard;
      logic [CfgWidth-1:0]    delay_ticks;
      seq_phase_e             phase;
      cmd_type                active_cmd;
      logic [BitCntWidth-1:0] bit_count;
      logic [ByteWidth-1:0]   shifter;
      logic [CfgWidth-1:0]    wait_count;
      logic                   scl;
      logic                   sda;
      logic [ByteWidth-1:0]   rd_hold;
      result_type             expected_q[$];
      int                     errors;

      function new();
         delay_ticks = DelayReset;
         phase       = PH_IDLE;
         active_cmd  = CMD_START;
         bit_count   = '0;
         shifter     = '0;
         wait_count  = '0;
         scl         = 1'b1;
         sda         = 1'b1;
         rd_hold     = '0;
         errors      = 0;
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10) begin
            $display("mismatch: %s", msg);
         end
      endfunction

      function bit is_idle();
         return phase == PH_IDLE;
      endfunction

      function bit awaiting_ack();
         return active_cmd == CMD_WRITE && (phase == PH_ACK_HIGH || phase == PH_ACK_POLL);
      endfunction

      // zero delay counts as one tick
      function void start_wait(seq_phase_e next_phase);
         phase      = next_phase;
         wait_count = (delay_ticks == '0) ? CfgWidth'(1) : delay_ticks;
      endfunction

      function bit wait_done();
         if (wait_count > 1) begin
            wait_count--;
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_word(bit cmd_valid, cmd_type mode, logic [ByteWidth-1:0] wr_data,
                              bit sda_in);
         bit done;
         done = 1'b0;
         case (phase)
            PH_IDLE: if (cmd_valid) begin
               active_cmd = mode;
               bit_count  = '0;
               case (mode)
                  CMD_START: begin
                     scl = 1'b1;
                     sda = 1'b1;
                     start_wait(PH_START_A);
                  end
                  CMD_STOP: begin
                     scl = 1'b0;
                     sda = 1'b0;
                     start_wait(PH_STOP_A);
                  end
                  CMD_WRITE: begin
                     scl     = 1'b1;
                     sda     = wr_data[7];
                     shifter = {wr_data[6:0], 1'b0};
                     start_wait(PH_BIT_HIGH);
                  end
                  default: begin
                     scl     = 1'b1;
                     sda     = 1'b1;
                     shifter = '0;
                     start_wait(PH_BIT_HIGH);
                  end
               endcase
            end
            PH_START_A: if (wait_done()) begin
               sda = 1'b0;
               start_wait(PH_START_B);
            end
            PH_START_B: if (wait_done()) begin
               scl   = 1'b0;
               phase = PH_IDLE;
               done  = 1'b1;
            end
            PH_STOP_A: if (wait_done()) begin
               scl = 1'b1;
               start_wait(PH_STOP_B);
            end
            PH_STOP_B: if (wait_done()) begin
               sda = 1'b1;
               start_wait(PH_STOP_C);
            end
            PH_STOP_C: if (wait_done()) begin
               phase = PH_IDLE;
               done  = 1'b1;
            end
            PH_BIT_HIGH: if (wait_done()) begin
               if (active_cmd == CMD_READ) begin
                  shifter = {shifter[6:0], sda_in};
               end
               scl = 1'b0;
               start_wait(PH_BIT_LOW);
            end
            PH_BIT_LOW: if (wait_done()) begin
               bit_count++;
               if (bit_count < BitsPerByte) begin
                  if (active_cmd == CMD_WRITE) begin
                     sda     = shifter[7];
                     shifter = {shifter[6:0], 1'b0};
                  end
                  scl = 1'b1;
                  start_wait(PH_BIT_HIGH);
               end else begin
                  scl = 1'b1;
                  sda = 1'b1;
                  start_wait(PH_ACK_HIGH);
               end
            end
            PH_ACK_HIGH: if (wait_done()) begin
               if (active_cmd == CMD_READ) begin
                  // NACK clock done, keep the byte
                  scl     = 1'b0;
                  rd_hold = shifter;
                  phase   = PH_IDLE;
                  done    = 1'b1;
               end else if (!sda_in) begin
                  scl = 1'b0;
                  start_wait(PH_ACK_LOW);
               end else begin
                  phase = PH_ACK_POLL;
               end
            end
            PH_ACK_POLL: if (!sda_in) begin
               scl = 1'b0;
               start_wait(PH_ACK_LOW);
            end
            PH_ACK_LOW: if (wait_done()) begin
               phase = PH_IDLE;
               done  = 1'b1;
            end
            default: phase = PH_IDLE;
         endcase
         expected_q.push_back('{rd_data: rd_hold, done: done, busy: (phase != PH_IDLE),
                                sda: sda, scl: scl});
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected word %h", got));
            return;
         end
         want = expected_q.pop_front();
         if (got.scl !== want.scl || got.sda !== want.sda || got.busy !== want.busy ||
             got.done !== want.done || got.rd_data !== want.rd_data) begin
            report($sformatf({"exp/act scl %b/%b sda %b/%b busy %b/%b done %b/%b",
                              " rd_data %h/%h"},
                             want.scl, got.scl, want.sda, got.sda, want.busy, got.busy,
                             want.done, got.done, want.rd_data, got.rd_data));
         end
      endfunction
   endclass

endpackage

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Top-level testbench for the I2C bit-bang master: stimulus, CSR access and checking.
module tb_top;
   import i2cbb_pkg::*;
   import i2c_tick_sb_pkg::*;

   localparam logic [CsrAddrWidth-1:0] RegDelayAddr = CsrDelayAddr;
   localparam int IdleLimit   = 5000;
   localparam int PhaseWords  = 80;
   localparam int DrainCycles = 10;
   localparam int RdLow       = 0;
   localparam int RdHigh      = 1;
   localparam int RdRandom    = 2;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [15:0]             req_tdata;   // wr_data[7:0], sda_in[8]
   logic [2:0]              req_tuser;   // cmd_valid[0], mode[2:1]
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [15:0]             rsp_tdata;   // scl[0], sda[1], busy[2], done[3], rd_data[11:4]
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   i2c_tick_scoreboard sb;
   int send_idle_pct;
   int recv_stall_pct;
   int ack_wait_left;
   int rd_level;
   int idle_cycles;

   i2c_bitbang_master_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(result_type'(rsp_tdata[11:0]));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // slave model: holds off the ACK for a while, read bits per rd_level
   function bit pick_sda();
      if (sb.awaiting_ack()) begin
         if (ack_wait_left > 0) begin
            ack_wait_left--;
            return 1'b1;
         end
         return 1'b0;
      end
      if (rd_level == RdRandom) begin
         return bit'($urandom_range(0, 1));
      end
      return bit'(rd_level);
   endfunction

   task send_word(bit cmd_valid, cmd_type mode, logic [7:0] wr_data);
      bit sda_in;
      sda_in = pick_sda();
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, sda_in, wr_data};
      req_tuser  <= {mode, cmd_valid};
      do @(posedge clock); while (!req_tready);
      sb.note_word(cmd_valid, mode, wr_data, sda_in);
   endtask

   task pause_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.expected_q.size() != 0);
   endtask

   // commands offered while busy must be ignored
   task finish_command();
      while (!sb.is_idle()) begin
         send_word(bit'($urandom_range(0, 1)), cmd_type'($urandom_range(0, 3)), 8'($urandom()));
      end
   endtask

   task run_cmd(cmd_type mode, logic [7:0] data, int ack_wait, int level);
      ack_wait_left = ack_wait;
      rd_level      = level;
      send_word(1'b1, mode, data);
      finish_command();
   endtask

   task csr_read_check();
      logic [CsrDataWidth-1:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= RegDelayAddr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got[CfgWidth-1:0] !== sb.delay_ticks) begin
         sb.report($sformatf("delay_ticks readback exp %h act %h", sb.delay_ticks,
                             got[CfgWidth-1:0]));
      end
   endtask

   task write_delay(logic [CsrDataWidth-1:0] value);
      finish_command();
      pause_until_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= RegDelayAddr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      sb.delay_ticks = value[CfgWidth-1:0];
      @(posedge clock);
      csr_read_check();
   endtask

   initial begin
      int p;
      int n;
      sb = new();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      ack_wait_left  = 0;
      rd_level       = RdRandom;
      idle_cycles    = 0;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      rsp_tready  <= 1'b1;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      csr_read_check();
      run_cmd(CMD_START, 8'h00, 0, RdRandom);
      write_delay(32'd1);
      run_cmd(CMD_WRITE, 8'hFF, 0, RdRandom);
      run_cmd(CMD_WRITE, 8'h00, 30, RdRandom);
      run_cmd(CMD_WRITE, 8'hA5, 1, RdRandom);
      run_cmd(CMD_READ, 8'h00, 0, RdHigh);
      run_cmd(CMD_READ, 8'hFF, 0, RdLow);
      run_cmd(CMD_READ, 8'h00, 0, RdRandom);
      run_cmd(CMD_STOP, 8'h00, 0, RdRandom);
      write_delay(32'd0);
      run_cmd(CMD_START, 8'h00, 0, RdRandom);
      run_cmd(CMD_WRITE, 8'h5A, 3, RdRandom);
      run_cmd(CMD_READ, 8'h00, 0, RdRandom);
      run_cmd(CMD_STOP, 8'h00, 0, RdRandom);
      write_delay(32'hFFFF_0003);
      run_cmd(CMD_WRITE, 8'h3C, 2, RdRandom);
      run_cmd(CMD_STOP, 8'h00, 0, RdRandom);
      write_delay(32'h0000_FFFF);

      for (p = 0; p < 8; p++) begin
         write_delay((p % 2 == 0) ? 32'd1 : 32'($urandom_range(0, 5)));
         case (p / 2)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 48;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 48;
            end
            default: begin
               send_idle_pct  = 14;
               recv_stall_pct = 14;
            end
         endcase
         for (n = 0; n < PhaseWords; n++) begin
            if (n == PhaseWords / 2) begin
               pause_until_drained();
            end
            if (sb.is_idle()) begin
               ack_wait_left = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30)
                                                           : $urandom_range(0, 2);
               rd_level      = RdRandom;
               send_word(bit'($urandom_range(0, 2) != 0), cmd_type'($urandom_range(0, 3)),
                         8'($urandom()));
            end else begin
               send_word(bit'($urandom_range(0, 3) == 0), cmd_type'($urandom_range(0, 3)),
                         8'($urandom()));
            end
         end
      end

      pause_until_drained();
      repeat (DrainCycles) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ i2c_bitbang_master_unit.f @@
design/i2cbb_pkg.sv
design/i2cbb_seq.sv
design/i2c_bitbang_master_unit.sv
tb/sv/i2c_tick_sb_pkg.sv
tb/sv/tb_top.sv
